FILE: design/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types, channel helpers and control/status bundles for the keyframe
// track sampler.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int unsigned NUM_CH   = 12;  // five signed values plus seven colour bytes
  localparam int unsigned CH_W     = 4;
  localparam int unsigned VAL_W    = 24;
  localparam int unsigned QUO_W    = 24;  // quotient magnitude stays below 2**24
  localparam logic        CMD_WRITE  = 1'b0;
  localparam logic        CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         frame_slot;
    logic [15:0]        delay;
    logic [1:0]         frame_flags;
    logic signed [23:0] position_x;
    logic signed [23:0] position_y;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [23:0] rotation;
    logic [31:0]        tint_rgba;
    logic [23:0]        offset_rgb;
    logic [23:0]        sample_time;
  } in_word_t;

  typedef struct packed {
    logic               visible;
    logic signed [23:0] out_position_x;
    logic signed [23:0] out_position_y;
    logic signed [23:0] out_scale_x;
    logic signed [23:0] out_scale_y;
    logic signed [23:0] out_rotation;
    logic [31:0]        out_tint_rgba;
    logic [23:0]        out_offset_rgb;
    logic [5:0]         hit_slot;
    logic               track_empty;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch sample time, clear walk
    logic walk_step;  // add delay to start, next frame
    logic latch_cur;
    logic addr_inc;
    logic latch_nxt;
    logic mul_load;
    logic div_init;
    logic div_step;
    logic wb;
    logic out_load;
  } kts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;
    logic hit;
    logic at_last;
    logic blend_ok;
    logic div_last;
    logic ch_last;
  } kts_sts_t;

  // Selects one channel of a frame as a 25-bit signed value.
  function automatic logic signed [24:0] chan_of(input logic [47:0] pos,
                                                 input logic [47:0] scl,
                                                 input logic [23:0] rot,
                                                 input logic [55:0] col,
                                                 input logic [CH_W-1:0] k);
    logic signed [24:0] v;
    v = '0;
    case (k)
      4'd0:    v = {pos[47], pos[47:24]};
      4'd1:    v = {pos[23], pos[23:0]};
      4'd2:    v = {scl[47], scl[47:24]};
      4'd3:    v = {scl[23], scl[23:0]};
      4'd4:    v = {rot[23], rot};
      4'd5:    v = {17'd0, col[55:48]};
      4'd6:    v = {17'd0, col[47:40]};
      4'd7:    v = {17'd0, col[39:32]};
      4'd8:    v = {17'd0, col[31:24]};
      4'd9:    v = {17'd0, col[23:16]};
      4'd10:   v = {17'd0, col[15:8]};
      4'd11:   v = {17'd0, col[7:0]};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/kts_ram.sv
// ----------------------------------------------------------------------------
// kts_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module kts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/kts_ctrl.sv
// ----------------------------------------------------------------------------
// kts_ctrl
// Sequencer for the sampler: walk, fetch, per-channel multiply and divide,
// and hand-off into the output register.
// ----------------------------------------------------------------------------
module kts_ctrl
  import kts_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  kts_sts_t sts,
  output kts_cmd_t cmd
);
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WALK_RD  = 4'd1;
  localparam logic [3:0] S_WALK_CHK = 4'd2;
  localparam logic [3:0] S_NXT_RD   = 4'd3;
  localparam logic [3:0] S_NXT_CHK  = 4'd4;
  localparam logic [3:0] S_MUL      = 4'd5;
  localparam logic [3:0] S_DIV_INIT = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_WB       = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       take;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign take      = in_valid && !in_stall && (in_cmd == CMD_SAMPLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.n_zero ? S_DONE : S_WALK_RD;
        end
      end
      S_WALK_RD: state_nxt = S_WALK_CHK;
      S_WALK_CHK: begin
        if (sts.hit || sts.at_last) begin
          cmd.latch_cur = 1'b1;
          if (sts.blend_ok) begin
            cmd.addr_inc = 1'b1;
            state_nxt    = S_NXT_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cmd.walk_step = 1'b1;
          cmd.addr_inc  = 1'b1;
          state_nxt     = S_WALK_RD;
        end
      end
      S_NXT_RD: state_nxt = S_NXT_CHK;
      S_NXT_CHK: begin
        cmd.latch_nxt = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = sts.ch_last ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

FILE: design/kts_dp.sv
// ----------------------------------------------------------------------------
// kts_dp
// Datapath: keyframe stores, span walk, shared multiply and restoring divider,
// result channels and the output register.
// ----------------------------------------------------------------------------
module kts_dp
  import kts_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 64,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      cfg_we,
  input  logic [6:0] cfg_wdata,
  input  kts_cmd_t  cmd,
  output kts_sts_t  sts,
  output out_word_t out_word
);
  localparam int unsigned AW = $clog2(MAX_FRAMES);
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned SW = 16 + CW;
  localparam int unsigned XW = (SW + FRAC_BITS > 24) ? SW + FRAC_BITS : 24;
  localparam int unsigned DW = 16 + FRAC_BITS;

  // Configuration register and effective track length.
  logic [6:0]    cfg_r;
  logic [CW-1:0] n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  assign n = (32'(cfg_r) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(cfg_r);

  // Stores.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] addr_r;
  logic [17:0]   df_q;
  logic [47:0]   pos_q, scl_q;
  logic [23:0]   rot_q;
  logic [55:0]   col_q;

  assign wr_en = in_valid && !in_stall && (in_word.cmd == CMD_WRITE) &&
                 (32'(in_word.frame_slot) < MAX_FRAMES);
  assign wr_addr = AW'(in_word.frame_slot);

  kts_ram #(.WIDTH(18), .DEPTH(MAX_FRAMES)) u_df (
    .clk, .we(wr_en), .waddr(wr_addr),
    .wdata({in_word.delay, in_word.frame_flags}), .raddr(addr_r), .rdata(df_q));
  kts_ram #(.WIDTH(48), .DEPTH(MAX_FRAMES)) u_pos (
    .clk, .we(wr_en), .waddr(wr_addr),
    .wdata({in_word.position_x, in_word.position_y}), .raddr(addr_r), .rdata(pos_q));
  kts_ram #(.WIDTH(48), .DEPTH(MAX_FRAMES)) u_scl (
    .clk, .we(wr_en), .waddr(wr_addr),
    .wdata({in_word.scale_x, in_word.scale_y}), .raddr(addr_r), .rdata(scl_q));
  kts_ram #(.WIDTH(24), .DEPTH(MAX_FRAMES)) u_rot (
    .clk, .we(wr_en), .waddr(wr_addr),
    .wdata(in_word.rotation), .raddr(addr_r), .rdata(rot_q));
  kts_ram #(.WIDTH(56), .DEPTH(MAX_FRAMES)) u_col (
    .clk, .we(wr_en), .waddr(wr_addr),
    .wdata({in_word.tint_rgba, in_word.offset_rgb}), .raddr(addr_r), .rdata(col_q));

  // Span walk.
  logic [23:0]   t_r;
  logic [SW-1:0] start_r;
  logic          empty_r;
  logic [15:0]   dl;
  logic [XW-1:0] lo, hi, t_ext;

  assign dl    = df_q[17:2];
  assign t_ext = XW'(t_r);
  assign lo    = XW'(start_r) << FRAC_BITS;
  assign hi    = (XW'(start_r) + XW'(dl)) << FRAC_BITS;

  assign sts.n_zero   = (n == '0);
  assign sts.hit      = (t_ext >= lo) && (t_ext < hi);
  assign sts.at_last  = (CW'(addr_r) == n - CW'(1));
  assign sts.blend_ok = sts.hit && df_q[0] && (dl > 16'd1) &&
                        ((CW'(addr_r) + CW'(1)) < n);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r     <= in_word.sample_time;
      start_r <= '0;
      addr_r  <= '0;
      empty_r <= sts.n_zero;
    end else begin
      if (cmd.walk_step) begin
        start_r <= start_r + SW'(dl);
      end
      if (cmd.addr_inc) begin
        addr_r <= addr_r + AW'(1);
      end
    end
  end

  // Current and next frame.
  logic          vis_r, blend_r;
  logic [5:0]    slot_r;
  logic [23:0]   e_r;
  logic [DW-1:0] d_r;
  logic [47:0]   a_pos_r, a_scl_r, b_pos_r, b_scl_r;
  logic [23:0]   a_rot_r, b_rot_r;
  logic [55:0]   a_col_r, b_col_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_cur) begin
      vis_r   <= df_q[1];
      blend_r <= sts.blend_ok;
      slot_r  <= 6'(addr_r);
      e_r     <= 24'(t_ext - lo);
      d_r     <= DW'(dl) << FRAC_BITS;
      a_pos_r <= pos_q;
      a_scl_r <= scl_q;
      a_rot_r <= rot_q;
      a_col_r <= col_q;
    end
    if (cmd.latch_nxt) begin
      b_pos_r <= pos_q;
      b_scl_r <= scl_q;
      b_rot_r <= rot_q;
      b_col_r <= col_q;
    end
  end

  // Shared multiply and restoring divide, one channel at a time.
  logic [CH_W-1:0]    ch_r;
  logic signed [24:0] a_ch, b_ch;
  logic signed [25:0] diff;
  logic [23:0]        mag;
  logic [47:0]        prod_r;
  logic               neg_r;
  logic [DW-1:0]      rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic [4:0]         cnt_r;
  logic [DW:0]        remsh;
  logic               ge;
  logic signed [24:0] q_s, blended;
  logic [23:0]        res_r [NUM_CH];

  assign a_ch  = chan_of(a_pos_r, a_scl_r, a_rot_r, a_col_r, ch_r);
  assign b_ch  = chan_of(b_pos_r, b_scl_r, b_rot_r, b_col_r, ch_r);
  assign diff  = 26'(b_ch) - 26'(a_ch);
  assign mag   = diff[25] ? 24'(-diff) : 24'(diff);
  assign remsh = {rem_r, quo_r[QUO_W-1]};
  assign ge    = remsh >= {1'b0, d_r};
  assign q_s   = {1'b0, quo_r};
  assign blended = a_ch + (neg_r ? -q_s : q_s);

  assign sts.div_last = (cnt_r == 5'(QUO_W - 1));
  assign sts.ch_last  = (ch_r == CH_W'(NUM_CH - 1));

  always_ff @(posedge clk) begin
    if (cmd.latch_nxt) begin
      ch_r <= '0;
    end else if (cmd.wb) begin
      ch_r <= ch_r + CH_W'(1);
    end
    if (cmd.mul_load) begin
      prod_r <= 48'(mag) * 48'(e_r);
      neg_r  <= diff[25];
    end
    if (cmd.div_init) begin
      rem_r <= DW'(prod_r[47:QUO_W]);
      quo_r <= prod_r[QUO_W-1:0];
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? DW'(remsh - {1'b0, d_r}) : DW'(remsh);
      quo_r <= {quo_r[QUO_W-2:0], ge};
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.wb) begin
      res_r[ch_r] <= blended[23:0];
    end
  end

  // Result assembly and output register.
  logic [23:0] fin [NUM_CH];
  out_word_t   res_word;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      fin[k] = blend_r ? res_r[k]
                       : 24'(chan_of(a_pos_r, a_scl_r, a_rot_r, a_col_r, CH_W'(k)));
    end
    res_word = '0;
    if (empty_r) begin
      res_word.track_empty = 1'b1;
    end else begin
      res_word.visible        = vis_r;
      res_word.out_position_x = fin[0];
      res_word.out_position_y = fin[1];
      res_word.out_scale_x    = fin[2];
      res_word.out_scale_y    = fin[3];
      res_word.out_rotation   = fin[4];
      res_word.out_tint_rgba  = {fin[5][7:0], fin[6][7:0], fin[7][7:0], fin[8][7:0]};
      res_word.out_offset_rgb = {fin[9][7:0], fin[10][7:0], fin[11][7:0]};
      res_word.hit_slot       = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word <= res_word;
    end
  end
endmodule

FILE: design/keyframe_track_sampler.sv
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// Keyframe table with linear blending toward the next frame at a sample time.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_stall, in_word) carries two kinds of
// word. A write word (cmd 0) fills one keyframe slot in the accept cycle and
// produces no result. A sample word (cmd 1) produces exactly one result word
// on the output channel (out_valid, out_stall, out_word).
// The cfg_we/cfg_wdata port sets the number of frames in use; write it only
// while no sample is in flight.
// Sequence of a sample: a memory read and a span compare for each frame walked,
// then a fetch of the next frame when blending, then for each of the twelve
// blended channels a multiply, divider setup, a 24-step restoring divide and
// a write-back, and last a load of the output register. An empty track goes
// straight to the output register load, and an unblended sample loads it
// after the walk. Once the result is loaded the sequencer returns to idle
// and can take the next word; the load waits while an earlier result is
// held under out_stall. The divider is the dominant cost.
// Write words are taken back to back while the block is idle.
// The block works on one sample at a time; in_stall is high while it runs.
// The result sits in an output register, so a new word may be accepted while
// an earlier result waits under out_stall; a stalled result holds steady.
// Synchronous reset clears the frame count to zero and drops any pending
// result. Keyframe memories are not cleared and hold garbage until written.
// ----------------------------------------------------------------------------
module keyframe_track_sampler
  import kts_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = 64,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);
  // Command and status bundles between the sequencer and the datapath.
  kts_cmd_t cmd;
  kts_sts_t sts;

  // The sequencer owns both handshakes; the datapath owns all payload.
  kts_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid, .in_cmd(in_word.cmd), .in_stall,
    .out_valid, .out_stall,
    .sts, .cmd
  );

  kts_dp #(.MAX_FRAMES(MAX_FRAMES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_word,
    .cfg_we, .cfg_wdata,
    .cmd, .sts, .out_word
  );
endmodule

FILE: design/kts_checker.sv
// ----------------------------------------------------------------------------
// kts_checker
// Port-level checks for the keyframe track sampler, bound to the top level.
// ----------------------------------------------------------------------------
module kts_checker
  import kts_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);
  // A pending word is not withdrawn under stall.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled word keeps its payload.
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  // An empty-track result has visible, hit_slot and tint cleared.
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.track_empty |->
      !out_word.visible && (out_word.hit_slot == 6'd0) &&
      (out_word.out_tint_rgba == 32'd0))
    else $error("empty track result has stray fields");

  // Reset leaves no result pending.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");
endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_word(out_word)
);
